FILE: hdl/lat_hist_pkg.sv
// Shared types and constants for the write-to-read latency histogram.
// Holds sizes, operation codes, controller state and command/status structs.
// No dependencies; every other file imports this package.
package lat_hist_pkg;

  localparam int NUM_BINS    = 40;
  localparam int BIN_WIDTH   = 5;
  localparam int COUNT_WIDTH = 32;

  // Fixed field widths of the channels
  localparam int OP_W    = 3;
  localparam int WORD_W  = 32;
  localparam int BCNT_W  = 32;
  localparam int HLEN_W  = 9;
  localparam int TICK_W  = 16;

  localparam int ELAPSED_MAX = NUM_BINS * BIN_WIDTH;
  localparam int EL_W        = $clog2(ELAPSED_MAX + 1);
  localparam int SUM_W       = ((EL_W > TICK_W) ? EL_W : TICK_W) + 1;
  localparam int BIN_AW      = $clog2(NUM_BINS);

  // Floor division by BIN_WIDTH as a multiply by a rounded-up reciprocal.
  // With DIV_SH = EL_W + ceil(log2(BIN_WIDTH)) the quotient is exact for
  // every EL_W-bit elapsed value.
  localparam int DIV_SH = EL_W + $clog2(BIN_WIDTH);
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << DIV_SH) + 64'(BIN_WIDTH) - 64'd1) / 64'(BIN_WIDTH);
  localparam int RECIP_W = DIV_SH + 1;
  localparam int PROD_W  = EL_W + RECIP_W;
  localparam int QUOT_W  = PROD_W - DIV_SH;

  localparam logic [TICK_W-1:0] TICK_US_RST = TICK_W'(1000);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_TICK    = 3'd2,
    OP_LENGTH  = 3'd3,
    OP_DUMP    = 3'd4,
    OP_INVALID = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    RESP_OK,
    RESP_READ,
    RESP_LEN,
    RESP_INVALID
  } resp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_UPD,
    ST_DUMP_RD,
    ST_DUMP_OUT
  } state_t;

  typedef struct packed {
    logic  wr_word;      // store word, restart elapsed counter
    logic  tick;         // advance elapsed counter
    logic  emit_simple;  // load output register with a single response
    resp_t resp;
    logic  rd_issue;     // read bin counter selected by elapsed time
    logic  rd_update;    // write back incremented counter
    logic  dump_start;   // clear dump index
    logic  dump_issue;   // read bin counter at dump index
    logic  dump_emit;    // load output register with dump count
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic dump_last;
  } stat_t;

endpackage

FILE: hdl/lat_hist_if.sv
// Valid/ready channel interfaces for the latency histogram block.
// Depends on lat_hist_pkg for field widths.
interface lat_hist_in_if import lat_hist_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [WORD_W-1:0] write_value;

  modport source (output valid, operation, write_value, input ready);
  modport sink   (input valid, operation, write_value, output ready);
endinterface

interface lat_hist_out_if import lat_hist_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] read_value;
  logic [BCNT_W-1:0]        bin_count;
  logic [HLEN_W-1:0]        hist_length;
  logic                     status;
  logic                     last;

  modport source (output valid, read_value, bin_count, hist_length, status, last,
                  input ready);
  modport sink   (input valid, read_value, bin_count, hist_length, status, last,
                  output ready);
endinterface

FILE: hdl/lat_hist_ctrl.sv
// Controller for the latency histogram: decodes operations and sequences
// the bin read-modify-write and the dump walk. Depends on lat_hist_pkg.
module lat_hist_ctrl import lat_hist_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_operation,
  output logic            in_ready,
  input  stat_t           stat,
  output cmd_t            cmd
);

  state_t state_r, state_nxt;
  logic   take;

  assign in_ready = (state_r == ST_IDLE) && stat.out_free;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          case (in_operation)
            OP_READ: state_nxt = ST_RD_UPD;
            OP_DUMP: state_nxt = ST_DUMP_RD;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD_UPD:  state_nxt = ST_IDLE;
      ST_DUMP_RD: state_nxt = ST_DUMP_OUT;
      ST_DUMP_OUT: begin
        if (stat.out_free) begin
          state_nxt = stat.dump_last ? ST_IDLE : ST_DUMP_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.resp = RESP_OK;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          case (in_operation)
            OP_WRITE: begin
              cmd.wr_word     = 1'b1;
              cmd.emit_simple = 1'b1;
              cmd.resp        = RESP_OK;
            end
            OP_READ: begin
              cmd.rd_issue    = 1'b1;
              cmd.emit_simple = 1'b1;
              cmd.resp        = RESP_READ;
            end
            OP_TICK: cmd.tick = 1'b1;
            OP_LENGTH: begin
              cmd.emit_simple = 1'b1;
              cmd.resp        = RESP_LEN;
            end
            OP_DUMP: cmd.dump_start = 1'b1;
            default: begin
              cmd.emit_simple = 1'b1;
              cmd.resp        = RESP_INVALID;
            end
          endcase
        end
      end
      ST_RD_UPD:   cmd.rd_update  = 1'b1;
      ST_DUMP_RD:  cmd.dump_issue = 1'b1;
      ST_DUMP_OUT: cmd.dump_emit  = stat.out_free;
      default: cmd = '0;
    endcase
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE)
    else $error("input accepted outside idle");

  a_upd_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |=> state_r == ST_RD_UPD)
    else $error("bin read not followed by update");

  a_dump_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.dump_emit && stat.dump_last) |=> state_r == ST_IDLE)
    else $error("dump did not end after last bin");

endmodule

FILE: hdl/lat_hist_dp.sv
// Datapath for the latency histogram: mailbox word, elapsed counter,
// bin counter memory with valid bits, dump index and output register.
// Depends on lat_hist_pkg.
module lat_hist_dp import lat_hist_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [TICK_W-1:0]        cfg_wdata,
  input  logic signed [WORD_W-1:0] in_write_value,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [WORD_W-1:0] out_read_value,
  output logic [BCNT_W-1:0]        out_bin_count,
  output logic [HLEN_W-1:0]        out_hist_length,
  output logic                     out_status,
  output logic                     out_last
);

  logic [TICK_W-1:0]        tick_us_r;
  logic signed [WORD_W-1:0] word_r;
  logic [EL_W-1:0]          elapsed_r;
  logic [SUM_W-1:0]         el_sum;

  logic [COUNT_WIDTH-1:0]   mem_r [NUM_BINS];
  logic [NUM_BINS-1:0]      vld_r;
  logic [COUNT_WIDTH-1:0]   rdata_r;
  logic                     rvld_r;
  logic [BIN_AW-1:0]        upd_addr_r;
  logic [BIN_AW-1:0]        idx_r;
  logic [BIN_AW-1:0]        rd_addr;
  logic [COUNT_WIDTH-1:0]   cnt;

  logic [PROD_W-1:0]        prod;
  logic [QUOT_W-1:0]        quot;
  logic [BIN_AW-1:0]        bin_idx;

  logic                     out_valid_r;
  logic signed [WORD_W-1:0] out_read_value_r;
  logic [BCNT_W-1:0]        out_bin_count_r;
  logic [HLEN_W-1:0]        out_hist_length_r;
  logic                     out_status_r;
  logic                     out_last_r;
  logic                     load;

  // Bin select: elapsed / BIN_WIDTH, clamped to the last bin
  assign prod = PROD_W'(elapsed_r) * PROD_W'(RECIP_VAL);
  assign quot = prod[PROD_W-1:DIV_SH];
  assign bin_idx = (quot >= QUOT_W'(NUM_BINS)) ? BIN_AW'(NUM_BINS - 1)
                                               : BIN_AW'(quot);

  assign el_sum  = SUM_W'(elapsed_r) + SUM_W'(tick_us_r);
  assign rd_addr = cmd.rd_issue ? bin_idx : idx_r;
  assign cnt     = rvld_r ? rdata_r : '0;

  assign load          = cmd.emit_simple || cmd.dump_emit;
  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.dump_last = (idx_r == BIN_AW'(NUM_BINS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_us_r <= TICK_US_RST;
      word_r    <= '0;
      elapsed_r <= EL_W'(ELAPSED_MAX);
      vld_r     <= '0;
    end else begin
      if (cfg_we) begin
        tick_us_r <= cfg_wdata;
      end
      if (cmd.wr_word) begin
        word_r    <= in_write_value;
        elapsed_r <= '0;
      end else if (cmd.tick) begin
        elapsed_r <= (el_sum > SUM_W'(ELAPSED_MAX)) ? EL_W'(ELAPSED_MAX)
                                                    : EL_W'(el_sum);
      end
      if (cmd.rd_update && (cnt != '1)) begin
        vld_r[upd_addr_r] <= 1'b1;
      end
    end
  end

  // Counter memory: one read and one write port, registered read data
  always_ff @(posedge clk) begin
    if (cmd.rd_issue || cmd.dump_issue) begin
      rdata_r <= mem_r[rd_addr];
      rvld_r  <= vld_r[rd_addr];
    end
    if (cmd.rd_issue) begin
      upd_addr_r <= bin_idx;
    end
    // Saturate: drop the write once the count is all ones
    if (cmd.rd_update && (cnt != '1)) begin
      mem_r[upd_addr_r] <= cnt + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.dump_start) begin
      idx_r <= '0;
    end else if (cmd.dump_emit && !stat.dump_last) begin
      idx_r <= idx_r + BIN_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_simple) begin
      out_read_value_r  <= (cmd.resp == RESP_READ) ? word_r : '0;
      out_bin_count_r   <= '0;
      out_hist_length_r <= (cmd.resp == RESP_LEN) ? HLEN_W'(NUM_BINS) : '0;
      out_status_r      <= (cmd.resp == RESP_INVALID);
      out_last_r        <= 1'b1;
    end else if (cmd.dump_emit) begin
      out_read_value_r  <= '0;
      out_bin_count_r   <= BCNT_W'(cnt);
      out_hist_length_r <= '0;
      out_status_r      <= 1'b0;
      out_last_r        <= stat.dump_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_bin_count   = out_bin_count_r;
  assign out_hist_length = out_hist_length_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while holding a result");

  a_elapsed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    elapsed_r <= EL_W'(ELAPSED_MAX))
    else $error("elapsed counter beyond saturation");

  a_bin_marked_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_update |=> vld_r[$past(upd_addr_r)])
    else $error("incremented bin not marked valid");

endmodule

FILE: hdl/write_to_read_latency_histogram.sv
// Top level of the write-to-read latency histogram mailbox.
// Depends on lat_hist_pkg, lat_hist_if, lat_hist_ctrl and lat_hist_dp.
//
// Usage:
//   in_ch  (sink)   : operation + write_value; transfer when valid && ready.
//   out_ch (source) : read_value, bin_count, hist_length, status, last.
//   cfg_we/cfg_wdata: writes tick_us (microseconds per tick operation).
// A write, length query or invalid request loads its result into the output
// register, visible the cycle after the transfer. A tick produces no result.
// A read reads the selected bin counter from the counter memory in the
// transfer cycle and writes the saturated increment back in ST_RD_UPD.
// A dump walks all NUM_BINS counters, reading each one from memory in
// ST_DUMP_RD and then loading it into the output register in ST_DUMP_OUT.
// in_ready is high only in idle with the output register empty or being
// taken; a stalled receiver holds the result and pauses a dump in place.
// Reset (synchronous, rst_n low) clears the word, saturates the elapsed
// counter, sets tick_us to 1000 and clears all bin valid bits at once, so
// no clearing pass is needed.
module write_to_read_latency_histogram import lat_hist_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  lat_hist_in_if.sink         in_ch,
  lat_hist_out_if.source      out_ch,
  input  logic                cfg_we,
  input  logic [TICK_W-1:0]   cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  lat_hist_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  lat_hist_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_write_value  (in_ch.write_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_read_value  (out_ch.read_value),
    .out_bin_count   (out_ch.bin_count),
    .out_hist_length (out_ch.hist_length),
    .out_status      (out_ch.status),
    .out_last        (out_ch.last)
  );

endmodule

FILE: verif/write_to_read_latency_histogram_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the write-to-read latency histogram mailbox.
// Depends on lat_hist_pkg, lat_hist_if and the write_to_read_latency_histogram RTL.
module write_to_read_latency_histogram_test;
  import lat_hist_pkg::*;

  localparam int     CLK_HALF      = 5;
  localparam int     RANDOM_ITEMS  = 216;
  localparam int     SETTLE_CYCLES = 8;
  localparam int     TAIL_CYCLES   = 20;
  localparam int     HOLD_AFTER    = 60;
  localparam int     LONG_HOLD     = 300;
  localparam longint TIMEOUT_NS    = 64'd10_000_000;

  // codes past the named operations; the block must flag them as invalid
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  typedef enum {RX_STREAM, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] value;
  } hist_request_t;

  typedef struct {
    logic signed [WORD_W-1:0] read_value;
    logic [BCNT_W-1:0]        bin_count;
    logic [HLEN_W-1:0]        hist_length;
    logic                     status;
    logic                     last;
  } hist_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [TICK_W-1:0] cfg_wdata;

  lat_hist_in_if  in_ch ();
  lat_hist_out_if out_ch ();

  write_to_read_latency_histogram dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predicted state of the block
  logic [TICK_W-1:0]        model_tick_us;
  logic signed [WORD_W-1:0] model_word;
  int                       model_elapsed;
  logic [BCNT_W-1:0]        model_bins [NUM_BINS];

  hist_request_t request_q [$];
  hist_result_t  expected_results [$];
  hist_request_t on_bus;

  int requests_accepted = 0;
  int results_checked   = 0;
  int mismatch_count    = 0;
  int reads_seen        = 0;
  int dumps_seen        = 0;
  int tick_settings     = 0;

  int burst_left = 1;
  int gap_left   = 0;

  int       hold_left      = 0;
  bit       long_hold_done = 1'b0;
  rx_mode_t rx_mode        = RX_STREAM;
  int       mode_left      = 0;
  int       stall_run      = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Advance the predicted state by one accepted request and queue its results.
  function automatic void apply_request(hist_request_t req);
    hist_result_t res;
    int bin;
    int sum;
    res = '{default: 0};
    res.last = 1'b1;
    case (req.op)
      OP_WRITE: begin
        model_word = req.value;
        model_elapsed = 0;
        expected_results.push_back(res);
      end
      OP_READ: begin
        bin = model_elapsed / BIN_WIDTH;
        if (bin > NUM_BINS - 1) bin = NUM_BINS - 1;
        if (model_bins[bin] != '1) model_bins[bin] = model_bins[bin] + 1'b1;
        res.read_value = model_word;
        expected_results.push_back(res);
        reads_seen++;
      end
      OP_TICK: begin
        sum = model_elapsed + int'(model_tick_us);
        model_elapsed = (sum > ELAPSED_MAX) ? ELAPSED_MAX : sum;
      end
      OP_LENGTH: begin
        res.hist_length = HLEN_W'(NUM_BINS);
        expected_results.push_back(res);
      end
      OP_DUMP: begin
        for (int i = 0; i < NUM_BINS; i++) begin
          res.bin_count = model_bins[i];
          res.last = (i == NUM_BINS - 1);
          expected_results.push_back(res);
        end
        dumps_seen++;
      end
      default: begin
        res.status = 1'b1;
        expected_results.push_back(res);
      end
    endcase
  endfunction

  // Sender: bursts of transfers with random gaps, fed from request_q.
  always @(posedge clk) begin : sender
    logic offer;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_request(on_bus);
        requests_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() != 0) begin
          on_bus = request_q.pop_front();
          offer = 1'b1;
          in_ch.operation   <= on_bus.op;
          in_ch.write_value <= on_bus.value;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_ch.valid <= offer;
      end
    end
  end

  // Receiver: stall pattern of its own, one long hold-off, and result checking.
  always @(posedge clk) begin : receiver
    hist_result_t want;
    logic rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = expected_results.pop_front();
          if (out_ch.read_value !== want.read_value)
            report_mismatch($sformatf("result %0d read_value %0d, want %0d",
                            results_checked, out_ch.read_value, want.read_value));
          if (out_ch.bin_count !== want.bin_count)
            report_mismatch($sformatf("result %0d bin_count %0d, want %0d",
                            results_checked, out_ch.bin_count, want.bin_count));
          if (out_ch.hist_length !== want.hist_length)
            report_mismatch($sformatf("result %0d hist_length %0d, want %0d",
                            results_checked, out_ch.hist_length, want.hist_length));
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("result %0d status %b, want %b",
                            results_checked, out_ch.status, want.status));
          if (out_ch.last !== want.last)
            report_mismatch($sformatf("result %0d last %b, want %b",
                            results_checked, out_ch.last, want.last));
        end
        results_checked++;
      end

      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!long_hold_done && requests_accepted >= HOLD_AFTER) begin
        // hold off long enough for the block to back up into the sender
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 64);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_STREAM:   rdy = 1'b1;
          RX_RANDOM:   rdy = (stall_run >= 4) || ($urandom_range(0, 2) != 0);
          default:     rdy = (stall_run >= 3);
        endcase
        stall_run = rdy ? 0 : stall_run + 1;
      end
      out_ch.ready <= rdy;
    end
  end

  task automatic push_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value);
    hist_request_t req;
    req.op = op;
    req.value = value;
    request_q.push_back(req);
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Wait until every request is taken and every result is back, then settle.
  task automatic drain_block();
    do @(negedge clk);
    while (request_q.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tick_us(input logic [TICK_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_tick_us = v;
    tick_settings++;
  endtask

  // Mostly write / ticks / reads sequences, with dumps, queries and noise mixed in.
  task automatic queue_random_phase(input int n_items);
    int queued;
    int roll;
    int cap;
    int n_ticks;
    int n_reads;
    queued = 0;
    cap = (model_tick_us == 0) ? 5 : ELAPSED_MAX / int'(model_tick_us) + 2;
    if (cap > 60) cap = 60;
    while (queued < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        push_request(OP_WRITE, random_word());
        n_ticks = ($urandom_range(0, 1) == 0) ? $urandom_range(0, cap) : $urandom_range(0, 4);
        repeat (n_ticks) push_request(OP_TICK, $urandom());
        n_reads = $urandom_range(1, 3);
        repeat (n_reads) push_request(OP_READ, $urandom());
        queued += 1 + n_ticks + n_reads;
      end else if (roll < 80) begin
        push_request(OP_DUMP, $urandom());
        queued++;
      end else if (roll < 86) begin
        push_request(OP_LENGTH, $urandom());
        queued++;
      end else if (roll < 93) begin
        case ($urandom_range(0, 2))
          0:       push_request(OP_INVALID, $urandom());
          1:       push_request(OP_UNUSED_6, $urandom());
          default: push_request(OP_UNUSED_7, $urandom());
        endcase
        queued++;
      end else begin
        // stray ticks and reads outside a sequence
        push_request(($urandom_range(0, 1) == 0) ? OP_TICK : OP_READ, $urandom());
        queued++;
      end
    end
    push_request(OP_DUMP, $urandom());
  endtask

  initial begin : timeout_guard
    #TIMEOUT_NS;
    $display("write_to_read_latency_histogram test failed");
    $finish;
  end

  initial begin : stimulus
    logic [TICK_W-1:0] phase_ticks [6];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.write_value = '0;
    out_ch.ready = 1'b0;
    model_tick_us = TICK_US_RST;
    model_word = '0;
    model_elapsed = ELAPSED_MAX;
    foreach (model_bins[i]) model_bins[i] = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset tick_us: read before any write lands in the last bin
    push_request(OP_READ, 32'h0);
    push_request(OP_LENGTH, 32'h0);
    push_request(OP_INVALID, 32'h0);
    push_request(OP_UNUSED_6, 32'h0);
    push_request(OP_UNUSED_7, 32'hFFFF_FFFF);
    push_request(OP_WRITE, 32'h7FFF_FFFF);
    push_request(OP_READ, 32'h0);
    push_request(OP_TICK, 32'h0);
    push_request(OP_READ, 32'h0);
    push_request(OP_WRITE, 32'h8000_0000);
    push_request(OP_READ, 32'h0);
    push_request(OP_WRITE, 32'hFFFF_FFFF);
    push_request(OP_WRITE, 32'h0);
    push_request(OP_READ, 32'h0);
    push_request(OP_DUMP, 32'h0);
    drain_block();

    // zero tick_us leaves the elapsed counter where it is
    set_tick_us(16'd0);
    push_request(OP_WRITE, 32'h5555_AAAA);
    push_request(OP_TICK, 32'h0);
    push_request(OP_READ, 32'h0);
    drain_block();

    set_tick_us(16'hFFFF);
    push_request(OP_WRITE, 32'hAAAA_5555);
    push_request(OP_TICK, 32'h0);
    push_request(OP_READ, 32'h0);
    drain_block();

    // one microsecond per tick: step across the first bin boundary
    set_tick_us(16'd1);
    push_request(OP_WRITE, 32'h1234_5678);
    repeat (4) push_request(OP_TICK, 32'h0);
    push_request(OP_READ, 32'h0);
    push_request(OP_TICK, 32'h0);
    push_request(OP_READ, 32'h0);
    push_request(OP_DUMP, 32'h0);
    drain_block();

    phase_ticks[0] = 16'd5;
    phase_ticks[1] = 16'd2;
    phase_ticks[2] = 16'd7;
    phase_ticks[3] = 16'hFFFF;
    phase_ticks[4] = 16'd13;
    phase_ticks[5] = TICK_W'($urandom_range(1, 300));
    foreach (phase_ticks[p]) begin
      set_tick_us(phase_ticks[p]);
      queue_random_phase(RANDOM_ITEMS / 6);
      drain_block();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d requests (%0d reads, %0d dumps) across %0d tick_us settings.",
             requests_accepted, reads_seen, dumps_seen, tick_settings);
    $display("Checked %0d results with %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("write_to_read_latency_histogram test passed");
    end else begin
      $display("write_to_read_latency_histogram test failed");
    end
    $finish;
  end

endmodule
